// File: design/dtq_pkg.sv
package dtq_pkg;

  localparam int TICK_W = 63;
  localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] GAP_LIMIT = TICK_W'(32'h7fff_ffff);
  localparam logic [30:0] MAX_WAIT_RST = 31'h7fff_ffff;

  // command codes
  localparam logic [2:0] CMD_ADD_REL   = 3'd0;
  localparam logic [2:0] CMD_ADD_ABS   = 3'd1;
  localparam logic [2:0] CMD_ABORT     = 3'd2;
  localparam logic [2:0] CMD_REMAINING = 3'd3;
  localparam logic [2:0] CMD_EXPIRES   = 3'd4;
  localparam logic [2:0] CMD_NEXT      = 3'd5;
  localparam logic [2:0] CMD_ANNOUNCE  = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_PROGRAM = 2'd2;

  // per-timer status
  localparam logic [1:0] TS_INACTIVE  = 2'd0;
  localparam logic [1:0] TS_QUEUED    = 2'd1;
  localparam logic [1:0] TS_ANNOUNCED = 2'd2;
  localparam logic [1:0] TS_ABORTED   = 2'd3;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

endpackage

// File: design/deadline_timeout_queue.sv
// Timer queue kept as a binary min-heap of deadlines, keyed by timer id,
// with a saturating 63-bit current tick that moves only on an announce.
// One command is taken at a time: in_ready is high only while the
// sequencer is idle. An add or an abort sifts one entry up or down the
// heap (log2 NUM_TIMERS levels at most), and a program-timer result
// follows when the root changes. An announce removes each expired timer
// with an expired result, then gives a closing program-timer result.
// Each level of the heap walk needs a heap-slot read, then a deadline
// read through registered memories with one read port each, then one
// pass through the shared compare unit. Results leave through one output
// register, so the sequencer stalls only when a beat is still waiting
// there.
module deadline_timeout_queue import dtq_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        cmd,
  input  logic [4:0]        timer_id,
  input  logic [TICK_W-1:0] ticks,
  input  logic              never_expire,
  input  logic [30:0]       elapsed_ticks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [4:0]        expired_id,
  output logic [TICK_W-1:0] value,
  output logic              status,
  output logic              last,
  input  logic              cfg_we,
  input  logic [30:0]       cfg_wdata
);

  localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW  = $clog2(NUM_TIMERS + 1);   // heap count / 1-based slot
  localparam int SW  = IDW + 2;                  // child index math

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_AR1, S_AR2, S_AB1, S_INS,
    S_SU0, S_SU1, S_SU2,
    S_SD0, S_SD1, S_SD2, S_SD3, S_SD4,
    S_RM0, S_RM1, S_RM2, S_HD,
    S_AN0, S_AN1, S_AN2, S_ANEND,
    S_NT0, S_NT1, S_NT2, S_NT3,
    S_REM, S_EMIT
  } state_t;

  state_t state, ret;

  // latched command
  logic [2:0]        cmd_q;
  logic [4:0]        tid_q;
  logic [TICK_W-1:0] ticks_q;
  logic              never_q;
  logic [30:0]       el_q;

  // queue state
  logic [TICK_W-1:0] cur;
  logic [CW-1:0]     count;
  logic [30:0]       max_wait;
  logic [1:0]        tstat [NUM_TIMERS];

  // heap walk registers
  logic [TICK_W-1:0] acc, cand_dl, mov_dl;
  logic [IDW-1:0]    slot, rm_slot, mov_id, cand_id, cand2_id, rm_id;
  logic [SW-1:0]     c;
  logic              root_hit;
  logic [30:0]       nt_el;
  logic [1:0]        nt_kind;

  // pending result beat
  logic [1:0]        res_kind;
  logic [4:0]        res_id;
  logic [TICK_W-1:0] res_val;
  logic              res_status, res_last;

  // memories
  logic [IDW-1:0]    order_mem [NUM_TIMERS];
  logic [CW-1:0]     pos_mem   [NUM_TIMERS];
  logic [TICK_W-1:0] dl_mem    [NUM_TIMERS];
  logic [IDW-1:0]    order_q;
  logic [CW-1:0]     pos_q;
  logic [TICK_W-1:0] dl_q;

  logic [IDW-1:0]    ord_raddr, dl_raddr, ord_waddr, ord_wdata, pos_waddr;
  logic [CW-1:0]     pos_wdata;
  logic              ord_we, pos_we, dl_we;

  // id decode
  logic [IDW+4:0]    in_wide, tid_wide;
  logic [IDW-1:0]    in_idx, tidx;
  logic              tid_ok;
  logic [1:0]        st_cur;

  assign in_wide  = (IDW+5)'(timer_id);
  assign in_idx   = in_wide[IDW-1:0];
  assign tid_wide = (IDW+5)'(tid_q);
  assign tidx     = tid_wide[IDW-1:0];
  assign tid_ok   = tid_wide < (IDW+5)'(NUM_TIMERS);
  assign st_cur   = tstat[tidx];

  // heap index arithmetic
  logic [IDW-1:0] parent;
  logic [SW-1:0]  c_first, c_next;
  assign parent  = IDW'((slot - IDW'(1)) >> 1);
  assign c_first = SW'({slot, 1'b1});
  assign c_next  = c + SW'(1);

  // shared adder / comparator
  logic [TICK_W-1:0] add_a, add_b, a_dl, b_dl, sum;
  logic [IDW-1:0]    a_id, b_id;
  logic              a_first;

  dtq_alu #(.IDW(IDW)) u_alu (
    .add_a(add_a), .add_b(add_b),
    .a_dl(a_dl), .a_id(a_id), .b_dl(b_dl), .b_id(b_id),
    .sum(sum), .a_first(a_first)
  );

  always_comb begin
    add_a = cur;
    add_b = '0;
    unique case (state)
      S_DISP: begin
        if (cmd_q == CMD_ADD_REL || cmd_q == CMD_REMAINING) begin
          add_b = TICK_W'(el_q);
        end else if (cmd_q == CMD_ADD_ABS) begin
          add_b = TICK_W'(1);
        end else begin
          add_b = ticks_q;
        end
      end
      S_AR1: begin
        add_a = acc;
        add_b = ticks_q;
      end
      S_AR2: begin
        add_a = acc;
        add_b = TICK_W'(1);
      end
      S_NT2:   add_b = TICK_W'(nt_el);
      default: add_b = '0;
    endcase
  end

  always_comb begin
    a_dl = cand_dl;
    a_id = cand_id;
    b_dl = mov_dl;
    b_id = mov_id;
    unique case (state)
      S_SU2: begin
        a_dl = mov_dl;
        a_id = mov_id;
        b_dl = dl_q;
        b_id = cand_id;
      end
      S_SD3: begin
        a_dl = dl_q;
        a_id = cand2_id;
        b_dl = cand_dl;
        b_id = cand_id;
      end
      default: begin
        a_dl = cand_dl;
      end
    endcase
  end

  // memory addressing
  always_comb begin
    ord_raddr = '0;
    unique case (state)
      S_SU0:   ord_raddr = parent;
      S_SD0:   ord_raddr = c_first[IDW-1:0];
      S_SD1:   ord_raddr = c_next[IDW-1:0];
      S_RM0:   ord_raddr = count[IDW-1:0];
      default: ord_raddr = '0;
    endcase
    dl_raddr = (state == S_IDLE) ? in_idx : order_q;
  end

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = slot;
    ord_wdata = mov_id;
    pos_waddr = mov_id;
    pos_wdata = CW'(slot) + CW'(1);
    unique case (state)
      S_INS: begin
        ord_we    = 1'b1;
        ord_waddr = count[IDW-1:0];
        ord_wdata = tidx;
        pos_waddr = tidx;
        pos_wdata = count + CW'(1);
      end
      S_SU0: ord_we = (slot == '0);
      S_SU2: begin
        ord_we = 1'b1;
        if (a_first) begin
          ord_wdata = cand_id;
          pos_waddr = cand_id;
        end
      end
      S_SD4: begin
        ord_we    = a_first;
        ord_wdata = cand_id;
        pos_waddr = cand_id;
      end
      S_RM2: begin
        ord_we    = 1'b1;
        ord_waddr = rm_slot;
        pos_wdata = CW'(rm_slot) + CW'(1);
      end
      default: ord_we = 1'b0;
    endcase
    pos_we = ord_we;
    dl_we  = (state == S_INS);
  end

  always_ff @(posedge clk) begin
    order_q <= order_mem[ord_raddr];
    dl_q    <= dl_mem[dl_raddr];
    pos_q   <= pos_mem[in_idx];
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (dl_we) begin
      dl_mem[tidx] <= acc;
    end
  end

  // next-ticks figure from root deadline and base
  logic [TICK_W:0]   gap;
  logic [TICK_W-1:0] nt_val, rem_val;
  assign gap     = {1'b0, cand_dl} - {1'b0, acc};
  assign nt_val  = (cand_dl <= acc) ? '0 :
                   (gap[TICK_W-1:0] > GAP_LIMIT) ? TICK_W'(max_wait) : gap[TICK_W-1:0];
  assign rem_val = (st_cur == TS_QUEUED && cand_dl > acc) ? gap[TICK_W-1:0] : '0;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      cur       <= '0;
      count     <= '0;
      max_wait  <= MAX_WAIT_RST;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tstat[i] <= TS_INACTIVE;
      end
    end else begin
      if (cfg_we) begin
        max_wait <= cfg_wdata;
      end
      // the emit state reloads the output register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            tid_q   <= timer_id;
            ticks_q <= ticks;
            never_q <= never_expire;
            el_q    <= elapsed_ticks;
            state   <= S_DISP;
          end
        end

        S_DISP: begin
          acc        <= sum;
          cand_dl    <= dl_q;
          res_kind   <= KIND_REPLY;
          res_id     <= '0;
          res_val    <= '0;
          res_status <= STAT_OK;
          res_last   <= 1'b1;
          ret        <= S_IDLE;
          state      <= S_EMIT;
          if (cmd_q <= CMD_EXPIRES && !tid_ok) begin
            res_status <= STAT_BAD;
          end else begin
            priority case (cmd_q)
              CMD_ADD_REL, CMD_ADD_ABS: begin
                if (never_q) begin
                  res_status <= STAT_OK;
                end else if (st_cur == TS_QUEUED) begin
                  res_status <= STAT_BAD;
                end else begin
                  state <= (cmd_q == CMD_ADD_REL) ? S_AR1 : S_AB1;
                end
              end
              CMD_ABORT: begin
                if (st_cur == TS_QUEUED) begin
                  count       <= count - CW'(1);
                  rm_slot     <= IDW'(pos_q - CW'(1));
                  root_hit    <= (pos_q == CW'(1));
                  tstat[tidx] <= TS_ABORTED;
                  state       <= S_RM0;
                end else if (st_cur == TS_ANNOUNCED) begin
                  tstat[tidx] <= TS_ABORTED;
                end else begin
                  res_status <= STAT_BAD;
                end
              end
              CMD_REMAINING: state   <= S_REM;
              CMD_EXPIRES:   res_val <= (st_cur == TS_QUEUED) ? dl_q : cur;
              CMD_NEXT: begin
                nt_el   <= el_q;
                nt_kind <= KIND_REPLY;
                state   <= S_NT0;
              end
              CMD_ANNOUNCE: state <= S_AN0;   // acc now holds the announce limit
              default:      res_status <= STAT_BAD;
            endcase
          end
        end

        S_AR1: begin
          acc   <= sum;
          state <= S_AR2;
        end
        S_AR2: begin
          acc   <= sum;
          state <= S_INS;
        end
        S_AB1: begin
          acc   <= (ticks_q > acc) ? ticks_q : acc;
          state <= S_INS;
        end

        S_INS: begin
          tstat[tidx] <= TS_QUEUED;
          count       <= count + CW'(1);
          mov_id      <= tidx;
          mov_dl      <= acc;
          slot        <= count[IDW-1:0];
          state       <= S_SU0;
        end

        // sift up
        S_SU0: begin
          if (slot == '0) begin
            if (cmd_q != CMD_ABORT) begin
              root_hit <= 1'b1;
            end
            state <= S_HD;
          end else begin
            state <= S_SU1;
          end
        end
        S_SU1: begin
          cand_id <= order_q;
          state   <= S_SU2;
        end
        S_SU2: begin
          if (a_first) begin
            slot  <= parent;
            state <= S_SU0;
          end else begin
            if (cmd_q != CMD_ABORT) begin
              root_hit <= 1'b0;
            end
            state <= S_HD;
          end
        end

        // sift down
        S_SD0: begin
          c     <= c_first;
          state <= (c_first >= SW'(count)) ? S_SU0 : S_SD1;
        end
        S_SD1: begin
          cand_id <= order_q;
          state   <= S_SD2;
        end
        S_SD2: begin
          cand_dl <= dl_q;
          if (c_next < SW'(count)) begin
            cand2_id <= order_q;
            state    <= S_SD3;
          end else begin
            state <= S_SD4;
          end
        end
        S_SD3: begin
          if (a_first) begin
            cand_id <= cand2_id;
            cand_dl <= dl_q;
            c       <= c_next;
          end
          state <= S_SD4;
        end
        S_SD4: begin
          if (a_first) begin
            slot  <= c[IDW-1:0];
            state <= S_SD0;
          end else begin
            state <= S_SU0;
          end
        end

        // removal: last entry fills the hole, then sifts
        S_RM0: begin
          state <= (SW'(count) == SW'(rm_slot)) ? S_HD : S_RM1;
        end
        S_RM1: begin
          mov_id <= order_q;
          state  <= S_RM2;
        end
        S_RM2: begin
          mov_dl <= dl_q;
          slot   <= rm_slot;
          state  <= S_SD0;
        end

        S_HD: begin
          res_kind   <= KIND_REPLY;
          res_id     <= '0;
          res_status <= STAT_OK;
          res_last   <= !root_hit;
          nt_el      <= el_q;
          nt_kind    <= KIND_PROGRAM;
          ret        <= root_hit ? S_NT0 : S_IDLE;
          priority case (cmd_q)
            CMD_ADD_REL, CMD_ADD_ABS: begin
              res_val <= acc;
              state   <= S_EMIT;
            end
            CMD_ABORT: begin
              res_val <= '0;
              state   <= S_EMIT;
            end
            default: state <= S_AN0;
          endcase
        end

        // announce loop
        S_AN0: state <= (count == '0) ? S_ANEND : S_AN1;
        S_AN1: begin
          rm_id <= order_q;
          state <= S_AN2;
        end
        S_AN2: begin
          if (dl_q <= acc) begin
            res_kind     <= KIND_EXPIRED;
            res_id       <= 5'(rm_id);
            res_val      <= dl_q;
            res_status   <= STAT_OK;
            res_last     <= 1'b0;
            tstat[rm_id] <= TS_ANNOUNCED;
            count        <= count - CW'(1);
            rm_slot      <= '0;
            ret          <= S_RM0;
            state        <= S_EMIT;
          end else begin
            state <= S_ANEND;
          end
        end
        S_ANEND: begin
          cur     <= acc;
          nt_el   <= '0;
          nt_kind <= KIND_PROGRAM;
          state   <= S_NT0;
        end

        // ticks to next deadline
        S_NT0: begin
          res_kind   <= nt_kind;
          res_id     <= '0;
          res_status <= STAT_OK;
          res_last   <= 1'b1;
          ret        <= S_IDLE;
          if (count == '0) begin
            res_val <= TICK_W'(max_wait);
            state   <= S_EMIT;
          end else begin
            state <= S_NT1;
          end
        end
        S_NT1: state <= S_NT2;
        S_NT2: begin
          cand_dl <= dl_q;
          acc     <= sum;
          state   <= S_NT3;
        end
        S_NT3: begin
          res_val <= nt_val;
          state   <= S_EMIT;
        end

        S_REM: begin
          res_val <= rem_val;
          state   <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            kind       <= res_kind;
            expired_id <= res_id;
            value      <= res_val;
            status     <= res_status;
            last       <= res_last;
            state      <= ret;
          end else begin
            out_valid <= 1'b1;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/dtq_alu.sv
module dtq_alu import dtq_pkg::*; #(
  parameter int IDW = 5
) (
  input  logic [TICK_W-1:0] add_a,
  input  logic [TICK_W-1:0] add_b,
  input  logic [TICK_W-1:0] a_dl,
  input  logic [IDW-1:0]    a_id,
  input  logic [TICK_W-1:0] b_dl,
  input  logic [IDW-1:0]    b_id,
  output logic [TICK_W-1:0] sum,
  output logic              a_first
);

  logic [TICK_W:0] raw;

  // saturating tick add; operands never exceed TICK_MAX
  assign raw = {1'b0, add_a} + {1'b0, add_b};
  assign sum = raw[TICK_W] ? TICK_MAX : raw[TICK_W-1:0];

  // heap order: earlier deadline first, lower id on a tie
  assign a_first = (a_dl < b_dl) || ((a_dl == b_dl) && (a_id < b_id));

endmodule
